// ----- src/tiled_rgb5a3_texel_decoder_unit_defines.svh -----
// Assertion macros shared by the checker of the tiled RGB5A3 texel decoder.
`ifndef TILED_RGB5A3_TEXEL_DECODER_UNIT_DEFINES_SVH
`define TILED_RGB5A3_TEXEL_DECODER_UNIT_DEFINES_SVH

// Checks a property at every rising clock edge, also while reset is held.
`define TRTD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checks a property at every rising clock edge outside of reset.
`define TRTD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- src/trtd_pkg.sv -----
// Package with the constants, register codes and decode functions of the texel decoder.
package trtd_pkg;

    localparam int TILE_SIZE          = 4;
    localparam int MAX_TILES_PER_SIDE = 256;

    localparam int TEXEL_W  = 16;
    localparam int ARGB_W   = 32;
    localparam int ADDR_W   = 20;
    localparam int TILES_W  = 9;
    localparam int TCNT_W   = 8;
    localparam int POS_W    = 2;
    localparam int COORD_W  = TCNT_W + POS_W;
    localparam int PITCH_W  = TILES_W + POS_W;
    localparam int PROD_W   = COORD_W + PITCH_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(TILE_SIZE - 1);
    localparam logic [TILES_W-1:0] TILES_MAX = TILES_W'(MAX_TILES_PER_SIDE);

    localparam logic [TILES_W-1:0] WIDTH_RESET  = 9'd24;
    localparam logic [TILES_W-1:0] HEIGHT_RESET = 9'd8;

    typedef enum logic [1:0] {
        REG_WIDTH_TILES  = 2'd0,
        REG_HEIGHT_TILES = 2'd1,
        REG_FORCE_OPAQUE = 2'd2
    } t_reg_idx;

    // A size of zero is used as one tile, a size above the maximum as the maximum.
    function automatic logic [TILES_W-1:0] clamp_tiles(input logic [TILES_W-1:0] v);
        logic [TILES_W-1:0] res;
        if (v == '0) begin
            res = TILES_W'(1);
        end else if (v > TILES_MAX) begin
            res = TILES_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Expands one RGB5A3 texel to ARGB8888 by bit replication.
    function automatic logic [ARGB_W-1:0] decode_texel(input logic [TEXEL_W-1:0] t,
                                                       input logic force_opaque);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (t[15]) begin
            r = {t[14:10], t[14:12]};
            g = {t[9:5], t[9:7]};
            b = {t[4:0], t[4:2]};
            a = 8'hff;
        end else begin
            r = {t[11:8], t[11:8]};
            g = {t[7:4], t[7:4]};
            b = {t[3:0], t[3:0]};
            a = {t[14:12], t[14:12], t[14:13]};
        end
        if (force_opaque) begin
            a = 8'hff;
        end
        return {a, r, g, b};
    endfunction

endpackage

// ----- src/tiled_rgb5a3_texel_decoder_unit.sv -----
// Top level of the tiled RGB5A3 texel decoder: position counters, decode and address pipeline.
// Two-stage pipeline: a result passes the input register, then the result register.
// Throughput: one texel per cycle while the output is not stalled.
// The input side keeps accepting while a result waits, until both stages hold an item.
// Reset (synchronous, active low) clears the pipeline valid bits and the tile counters and
// loads the size registers with 24 by 8 tiles and force-opaque set.
module tiled_rgb5a3_texel_decoder_unit
    import trtd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Texel input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TEXEL_W-1:0] i_texel,
    // Pixel output channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ARGB_W-1:0]  o_argb,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic               o_last_pixel,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers.
    logic [TILES_W-1:0] r_width_tiles;
    logic [TILES_W-1:0] r_height_tiles;
    logic               r_force_opaque;

    // Position counters: where the next accepted texel lands in the image.
    logic [POS_W-1:0]  r_col_in_tile, n_col_in_tile;
    logic [POS_W-1:0]  r_row_in_tile, n_row_in_tile;
    logic [TCNT_W-1:0] r_tile_column, n_tile_column;
    logic [TCNT_W-1:0] r_tile_row,    n_tile_row;

    // Stage one holds the texel with its raster row, column and last flag.
    logic               r_s1_valid;
    logic [TEXEL_W-1:0] r_s1_texel;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;
    logic               r_s1_last;

    // Stage two is the result register that drives the output channel.
    logic               r_s2_valid;
    logic [ARGB_W-1:0]  r_s2_argb;
    logic [ADDR_W-1:0]  r_s2_addr;
    logic               r_s2_last;

    logic               w_cfg_write;
    t_reg_idx           w_cfg_idx;
    logic [TILES_W-1:0] w_width;
    logic [TILES_W-1:0] w_height;
    logic               w_in_xfer;
    logic               w_s2_load;
    logic               w_s1_load;
    logic               w_tile_end;
    logic               w_col_done;
    logic               w_row_done;
    logic               w_last;
    logic [PITCH_W-1:0] w_pitch;
    logic [PROD_W-1:0]  w_prod;
    logic [ADDR_W-1:0]  w_addr;

    // The APB port never stalls; a write lands in the access cycle.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_cfg_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_tiles  <= WIDTH_RESET;
            r_height_tiles <= HEIGHT_RESET;
            r_force_opaque <= 1'b1;
        end else if (w_cfg_write) begin
            unique case (w_cfg_idx)
                REG_WIDTH_TILES:  r_width_tiles  <= pwdata[TILES_W-1:0];
                REG_HEIGHT_TILES: r_height_tiles <= pwdata[TILES_W-1:0];
                REG_FORCE_OPAQUE: r_force_opaque <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Reads return the stored value, so an out-of-range size reads back as written.
    always_comb begin
        unique case (w_cfg_idx)
            REG_WIDTH_TILES:  prdata = PDATA_W'(r_width_tiles);
            REG_HEIGHT_TILES: prdata = PDATA_W'(r_height_tiles);
            REG_FORCE_OPAQUE: prdata = PDATA_W'(r_force_opaque);
            default:          prdata = '0;
        endcase
    end

    // The clamped sizes are what the counters and the address use.
    assign w_width  = clamp_tiles(r_width_tiles);
    assign w_height = clamp_tiles(r_height_tiles);

    // Handshake: the result register loads when it is empty or being emptied, and
    // stage one moves on whenever the result register takes its item.
    assign w_s2_load = !r_s2_valid || i_ready;
    assign w_s1_load = !r_s1_valid || w_s2_load;
    assign o_ready   = w_s1_load;
    assign w_in_xfer = i_valid && o_ready;

    // A tile counter that already stands at or past a shrunk size counts as done,
    // so it wraps at the next tile boundary.
    assign w_tile_end = (r_col_in_tile == POS_LAST) && (r_row_in_tile == POS_LAST);
    assign w_col_done = ({1'b0, r_tile_column} + TILES_W'(1)) >= w_width;
    assign w_row_done = ({1'b0, r_tile_row} + TILES_W'(1)) >= w_height;
    assign w_last     = w_tile_end && w_col_done && w_row_done;

    // Counter step: column in tile, then row in tile, then tile column, then tile row.
    always_comb begin
        n_col_in_tile = r_col_in_tile;
        n_row_in_tile = r_row_in_tile;
        n_tile_column = r_tile_column;
        n_tile_row    = r_tile_row;
        if (w_last) begin
            n_col_in_tile = '0;
            n_row_in_tile = '0;
            n_tile_column = '0;
            n_tile_row    = '0;
        end else if (r_col_in_tile != POS_LAST) begin
            n_col_in_tile = r_col_in_tile + POS_W'(1);
        end else begin
            n_col_in_tile = '0;
            if (r_row_in_tile != POS_LAST) begin
                n_row_in_tile = r_row_in_tile + POS_W'(1);
            end else begin
                n_row_in_tile = '0;
                if (!w_col_done) begin
                    n_tile_column = r_tile_column + TCNT_W'(1);
                end else begin
                    n_tile_column = '0;
                    if (!w_row_done) begin
                        n_tile_row = r_tile_row + TCNT_W'(1);
                    end else begin
                        n_tile_row = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in_tile <= '0;
            r_row_in_tile <= '0;
            r_tile_column <= '0;
            r_tile_row    <= '0;
        end else if (w_in_xfer) begin
            r_col_in_tile <= n_col_in_tile;
            r_row_in_tile <= n_row_in_tile;
            r_tile_column <= n_tile_column;
            r_tile_row    <= n_tile_row;
        end
    end

    // Stage one captures the texel and its image position at the input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_texel <= i_texel;
            r_s1_row   <= {r_tile_row, r_row_in_tile};
            r_s1_col   <= {r_tile_column, r_col_in_tile};
            r_s1_last  <= w_last;
        end
    end

    // Raster address: row times the padded width in texels plus column, kept to 20 bits.
    // Change configuration only while the pipeline is empty; the block does not enforce this.
    assign w_pitch = {w_width, POS_W'(0)};
    assign w_prod  = PROD_W'(r_s1_row) * PROD_W'(w_pitch);
    assign w_addr  = ADDR_W'(w_prod + PROD_W'(r_s1_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && r_s1_valid) begin
            r_s2_argb <= decode_texel(r_s1_texel, r_force_opaque);
            r_s2_addr <= w_addr;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_argb          = r_s2_argb;
    assign o_pixel_address = r_s2_addr;
    assign o_last_pixel    = r_s2_last;

endmodule

// ----- src/trtd_checker.sv -----
// Port-level checker of the texel decoder and the bind that attaches it.
`include "tiled_rgb5a3_texel_decoder_unit_defines.svh"

module trtd_checker
    import trtd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [ARGB_W-1:0]  o_argb,
    input logic [ADDR_W-1:0]  o_pixel_address,
    input logic               o_last_pixel
);

    // Set when the next pixel to come out starts a new image.
    logic r_after_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (o_valid && i_ready) begin
            r_after_last <= o_last_pixel;
        end
    end

    `TRTD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")
    `TRTD_ASSERT_RUN(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "input stalled while output is empty")
    `TRTD_ASSERT_RUN(a_ready_when_drain, i_clk, i_rst_n, (o_valid && i_ready) |-> o_ready, "input stalled while output drains")
    `TRTD_ASSERT_RUN(a_image_starts_zero, i_clk, i_rst_n, (o_valid && r_after_last) |-> (o_pixel_address == '0), "first pixel of an image not at address zero")
    `TRTD_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_argb) && $stable(o_pixel_address)), "stalled result changed")

endmodule

bind tiled_rgb5a3_texel_decoder_unit trtd_checker u_trtd_checker (.*);
